FILE: rtl/bre_pkg.sv
// bre_pkg: shared types, command and status codes and the popcount function
// for the bit vector rank engine; no dependencies
package bre_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_W     = 17;   // word counts up to 65536
    localparam int USE_W     = 23;   // usable bit counts up to 65536 words of 64
    localparam int LEN_W     = 17;
    localparam int RATE_W    = 11;
    localparam int WIDX_W    = 10;   // word part of a 16-bit bit index

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_READ  = 3'd2,
        CMD_BUILD = 3'd3,
        CMD_RANK  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_UNBUILT  = 2'd2
    } status_t;

    localparam logic REG_LENGTH = 1'b0;
    localparam logic REG_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDW,
        S_RMW,
        S_DIV,
        S_SRD,
        S_SACC,
        S_WRD,
        S_WACC,
        S_LAST,
        S_BRD,
        S_BACC,
        S_DONE
    } state_t;

    function automatic logic [6:0] pop64(input logic [63:0] v);
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] b;
        y = v - ((v >> 1) & 64'h5555555555555555);
        z = (y & 64'h3333333333333333) + ((y >> 2) & 64'h3333333333333333);
        b = (z + (z >> 4)) & 64'h0f0f0f0f0f0f0f0f;
        pop64 = 7'(b[7:0]) + 7'(b[15:8]) + 7'(b[23:16]) + 7'(b[31:24])
              + 7'(b[39:32]) + 7'(b[47:40]) + 7'(b[55:48]) + 7'(b[63:56]);
    endfunction

endpackage

FILE: rtl/bitvector_rank_engine_top.sv
// bitvector_rank_engine_top: bit vector store with sampled rank queries
// depends on bre_pkg
//
// One transaction at a time, one shared popcount and add unit over one read
// port of each store. Load word and rejected commands go to the done state;
// read or write bit reads then writes the word or keeps the bit; build and
// rank read and add one bit store word at a time, which sets the pace; rank
// first divides the word index bit-serially by the sample rate.
// A finished result waits in the output register; the next command is taken
// once that result has left the sequencer.
module bitvector_rank_engine_top #(
    parameter int MAX_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  command,
    input  logic [15:0] bit_index,
    input  logic        bit_value,
    input  logic [9:0]  word_index,
    input  logic [63:0] word_value,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  status,
    output logic        bit_out,
    output logic [16:0] rank_out
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam logic [bre_pkg::USE_W-1:0] CAP_BITS =
        bre_pkg::USE_W'(MAX_WORDS * bre_pkg::WORD_BITS);

    logic [63:0] bit_store [MAX_WORDS];
    logic [16:0] sample_store [MAX_WORDS];

    bre_pkg::state_t state_reg, state_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [15:0] bi_reg, bi_next;
    logic        bv_reg, bv_next;
    logic [bre_pkg::LEN_W-1:0]  length_reg, length_next;
    logic [bre_pkg::RATE_W-1:0] sample_reg, sample_next;
    logic        built_reg, built_next;
    logic [bre_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [bre_pkg::RATE_W-1:0] phase_reg, phase_next;
    logic [AW-1:0] sidx_reg, sidx_next;
    logic [16:0] acc_reg, acc_next;
    logic [10:0] rem_reg, rem_next;
    logic [9:0]  dq_reg, dq_next;
    logic [3:0]  dstep_reg, dstep_next;
    logic [1:0]  pst_reg, pst_next;
    logic        pbit_reg, pbit_next;
    logic        res_valid_reg, res_valid_next;
    logic [1:0]  status_reg, status_next;
    logic        bit_out_reg, bit_out_next;
    logic [16:0] rank_reg, rank_next;

    logic        bs_we, bs_re, ss_we, ss_re;
    logic [AW-1:0] bs_waddr, bs_raddr, ss_waddr, ss_raddr;
    logic [63:0] bs_wdata, bs_rdata;
    logic [16:0] ss_wdata, ss_rdata;

    logic [bre_pkg::USE_W-1:0] len_ext, nbits;
    logic [bre_pkg::USE_W-1:0] nwords_wide;
    logic [bre_pkg::CNT_W-1:0] nwords;
    logic [bre_pkg::RATE_W-1:0] k_val;
    logic [9:0]  w_reg;
    logic [5:0]  off_reg;
    logic [63:0] pop_in;
    logic [6:0]  pop_cnt;
    logic [16:0] acc_sum;
    logic [11:0] div_tmp;
    logic        div_ge;
    logic        accept;
    logic        out_free;
    logic        bld_last;

    assign len_ext     = bre_pkg::USE_W'(length_reg);
    assign nbits       = (len_ext < CAP_BITS) ? len_ext : CAP_BITS;
    assign nwords_wide = (nbits + bre_pkg::USE_W'(63)) >> 6;
    assign nwords      = nwords_wide[bre_pkg::CNT_W-1:0];
    assign k_val       = (sample_reg == '0) ? bre_pkg::RATE_W'(1) : sample_reg;
    assign w_reg       = bi_reg[15:6];
    assign off_reg     = bi_reg[5:0];
    assign accept      = cmd_valid && cmd_ready;
    assign out_free    = !res_valid_reg || res_ready;
    assign bld_last    = (cnt_reg + bre_pkg::CNT_W'(1)) == nwords;

    // shared popcount and accumulate unit
    assign pop_in  = (state_reg == bre_pkg::S_LAST)
                   ? (bs_rdata & ({64{1'b1}} >> (6'd63 - off_reg))) : bs_rdata;
    assign pop_cnt = bre_pkg::pop64(pop_in);
    assign acc_sum = acc_reg + 17'(pop_cnt);

    // bit-serial restoring divide of the word index by the sample rate
    assign div_tmp = {rem_reg, dq_reg[9]};
    assign div_ge  = div_tmp >= {1'b0, k_val};

    assign cmd_ready = (state_reg == bre_pkg::S_IDLE);
    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign bit_out   = bit_out_reg;
    assign rank_out  = rank_reg;

    always_ff @(posedge clk)
    begin
        if (bs_we)
        begin
            bit_store[bs_waddr] <= bs_wdata;
        end
        if (bs_re)
        begin
            bs_rdata <= bit_store[bs_raddr];
        end
        if (ss_we)
        begin
            sample_store[ss_waddr] <= ss_wdata;
        end
        if (ss_re)
        begin
            ss_rdata <= sample_store[ss_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bre_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = bre_pkg::S_DONE;
                    case (command)
                        bre_pkg::CMD_WRITE, bre_pkg::CMD_READ, bre_pkg::CMD_RANK:
                        begin
                            if (bre_pkg::USE_W'(bit_index) < nbits)
                            begin
                                if (command != bre_pkg::CMD_RANK)
                                begin
                                    state_next = bre_pkg::S_RDW;
                                end
                                else if (built_reg)
                                begin
                                    state_next = bre_pkg::S_DIV;
                                end
                            end
                        end
                        bre_pkg::CMD_BUILD:
                        begin
                            if (nwords != '0)
                            begin
                                state_next = bre_pkg::S_BRD;
                            end
                        end
                        default: state_next = bre_pkg::S_DONE;
                    endcase
                end
            end
            bre_pkg::S_RDW:  state_next = bre_pkg::S_RMW;
            bre_pkg::S_RMW:  state_next = bre_pkg::S_DONE;
            bre_pkg::S_DIV:
            begin
                if (dstep_reg == 4'd1)
                begin
                    state_next = bre_pkg::S_SRD;
                end
            end
            bre_pkg::S_SRD:  state_next = bre_pkg::S_SACC;
            bre_pkg::S_SACC: state_next = bre_pkg::S_WRD;
            bre_pkg::S_WRD:
            begin
                if (cnt_reg == bre_pkg::CNT_W'(w_reg))
                begin
                    state_next = bre_pkg::S_LAST;
                end
                else
                begin
                    state_next = bre_pkg::S_WACC;
                end
            end
            bre_pkg::S_WACC: state_next = bre_pkg::S_WRD;
            bre_pkg::S_LAST: state_next = bre_pkg::S_DONE;
            bre_pkg::S_BRD:  state_next = bre_pkg::S_BACC;
            bre_pkg::S_BACC:
            begin
                state_next = bld_last ? bre_pkg::S_DONE : bre_pkg::S_BRD;
            end
            bre_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bre_pkg::S_IDLE;
                end
            end
            default: state_next = bre_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd_next       = cmd_reg;
        bi_next        = bi_reg;
        bv_next        = bv_reg;
        length_next    = length_reg;
        sample_next    = sample_reg;
        built_next     = built_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        sidx_next      = sidx_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        dstep_next     = dstep_reg;
        pst_next       = pst_reg;
        pbit_next      = pbit_reg;
        res_valid_next = res_valid_reg && !res_ready;
        status_next    = status_reg;
        bit_out_next   = bit_out_reg;
        rank_next      = rank_reg;
        bs_we    = 1'b0;
        bs_waddr = AW'(cnt_reg);
        bs_wdata = bs_rdata;
        bs_re    = 1'b0;
        bs_raddr = AW'(cnt_reg);
        ss_we    = 1'b0;
        ss_waddr = sidx_reg;
        ss_wdata = acc_reg;
        ss_re    = 1'b0;
        ss_raddr = AW'(dq_reg);
        case (state_reg)
            bre_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = command;
                    bi_next   = bit_index;
                    bv_next   = bit_value;
                    pst_next  = bre_pkg::ST_OK;
                    pbit_next = 1'b0;
                    acc_next  = '0;
                    cnt_next  = '0;
                    phase_next = '0;
                    sidx_next = '0;
                    rem_next  = '0;
                    dq_next   = bit_index[15:6];
                    dstep_next = 4'd10;
                    case (command)
                        bre_pkg::CMD_LOAD:
                        begin
                            if (bre_pkg::CNT_W'(word_index) >= nwords)
                            begin
                                pst_next = bre_pkg::ST_RANGE;
                            end
                            else
                            begin
                                bs_we      = 1'b1;
                                bs_waddr   = AW'(word_index);
                                bs_wdata   = word_value;
                                built_next = 1'b0;
                            end
                        end
                        bre_pkg::CMD_WRITE, bre_pkg::CMD_READ, bre_pkg::CMD_RANK:
                        begin
                            if (bre_pkg::USE_W'(bit_index) >= nbits)
                            begin
                                pst_next = bre_pkg::ST_RANGE;
                            end
                            else if (command == bre_pkg::CMD_RANK && !built_reg)
                            begin
                                pst_next = bre_pkg::ST_UNBUILT;
                            end
                        end
                        bre_pkg::CMD_BUILD:
                        begin
                            if (nwords == '0)
                            begin
                                built_next = 1'b1;
                            end
                        end
                        default: pst_next = bre_pkg::ST_OK;
                    endcase
                end
            end
            bre_pkg::S_RDW:
            begin
                bs_re    = 1'b1;
                bs_raddr = AW'(w_reg);
            end
            bre_pkg::S_RMW:
            begin
                if (cmd_reg == bre_pkg::CMD_WRITE)
                begin
                    bs_we      = 1'b1;
                    bs_waddr   = AW'(w_reg);
                    bs_wdata   = bs_rdata;
                    bs_wdata[off_reg] = bv_reg;
                    built_next = 1'b0;
                end
                else
                begin
                    pbit_next = bs_rdata[off_reg];
                end
            end
            bre_pkg::S_DIV:
            begin
                rem_next   = div_ge ? 11'(div_tmp - {1'b0, k_val}) : div_tmp[10:0];
                dq_next    = {dq_reg[8:0], div_ge};
                dstep_next = dstep_reg - 4'd1;
            end
            bre_pkg::S_SRD:
            begin
                // first word of the superblock is index minus remainder
                ss_re    = 1'b1;
                ss_raddr = AW'(dq_reg);
                cnt_next = bre_pkg::CNT_W'(11'(w_reg) - rem_reg);
            end
            bre_pkg::S_SACC:
            begin
                acc_next = ss_rdata;
            end
            bre_pkg::S_WRD:
            begin
                bs_re    = 1'b1;
                bs_raddr = AW'(cnt_reg);
            end
            bre_pkg::S_WACC:
            begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + bre_pkg::CNT_W'(1);
            end
            bre_pkg::S_LAST:
            begin
                acc_next = acc_sum;
            end
            bre_pkg::S_BRD:
            begin
                bs_re    = 1'b1;
                bs_raddr = AW'(cnt_reg);
                if (phase_reg == '0)
                begin
                    ss_we     = 1'b1;
                    ss_waddr  = sidx_reg;
                    ss_wdata  = acc_reg;
                    sidx_next = sidx_reg + AW'(1);
                end
            end
            bre_pkg::S_BACC:
            begin
                acc_next   = acc_sum;
                cnt_next   = cnt_reg + bre_pkg::CNT_W'(1);
                phase_next = (phase_reg + bre_pkg::RATE_W'(1) == k_val)
                           ? '0 : phase_reg + bre_pkg::RATE_W'(1);
                if (bld_last)
                begin
                    built_next = 1'b1;
                end
            end
            bre_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = pst_reg;
                    bit_out_next   = (cmd_reg == bre_pkg::CMD_READ && pst_reg == bre_pkg::ST_OK)
                                   ? pbit_reg : 1'b0;
                    rank_next      = (cmd_reg == bre_pkg::CMD_RANK && pst_reg == bre_pkg::ST_OK)
                                   ? acc_reg : 17'd0;
                end
            end
            default: acc_next = acc_reg;
        endcase
        if (cfg_we)
        begin
            built_next = 1'b0;
            case (cfg_index)
                bre_pkg::REG_LENGTH: length_next = cfg_data[bre_pkg::LEN_W-1:0];
                bre_pkg::REG_SAMPLE: sample_next = cfg_data[bre_pkg::RATE_W-1:0];
                default: length_next = length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bre_pkg::S_IDLE;
            length_reg    <= '0;
            sample_reg    <= bre_pkg::RATE_W'(1);
            built_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            sample_reg    <= sample_next;
            built_reg     <= built_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        bi_reg      <= bi_next;
        bv_reg      <= bv_next;
        cnt_reg     <= cnt_next;
        phase_reg   <= phase_next;
        sidx_reg    <= sidx_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        dstep_reg   <= dstep_next;
        pst_reg     <= pst_next;
        pbit_reg    <= pbit_next;
        status_reg  <= status_next;
        bit_out_reg <= bit_out_next;
        rank_reg    <= rank_next;
    end

    // any configuration write drops the built samples
    a_cfg_clears_built: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !built_reg)
        else $error("built mark survived a configuration write");

    // samples only become valid at the end of a build
    a_built_from_build: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> ($past(state_reg) == bre_pkg::S_BACC
            || ($past(state_reg) == bre_pkg::S_IDLE && $past(cmd_valid)
                && $past(command) == bre_pkg::CMD_BUILD)))
        else $error("built mark set outside a build");

    // divide leaves a remainder below the sample rate
    a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bre_pkg::S_SRD |-> rem_reg < k_val)
        else $error("divide remainder not below sample rate");

    // rank walk never passes the word holding the index
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bre_pkg::S_WRD |-> cnt_reg <= bre_pkg::CNT_W'(w_reg))
        else $error("rank walk ran past the index word");

endmodule

FILE: tb/sv/tb_bitvector_rank_engine_top.sv
// tb_bitvector_rank_engine_top: self-checking bench for the bit vector rank engine
// depends on bre_pkg and bitvector_rank_engine_top; a queue-fed driver, a monitor
// and an in-bench predictor of the vector, the samples and the built flag
module tb_bitvector_rank_engine_top;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] bidx;
        logic        bval;
        logic [9:0]  widx;
        logic [63:0] wval;
    } cmd_item_t;

    typedef struct {
        bre_pkg::status_t st;
        logic             bit_o;
        logic [16:0]      rank;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;
    logic        cmd_valid;
    logic        cmd_ready;
    logic [2:0]  command;
    logic [15:0] bit_index;
    logic        bit_value;
    logic [9:0]  word_index;
    logic [63:0] word_value;
    logic        res_valid;
    logic        res_ready;
    logic [1:0]  status;
    logic        bit_out;
    logic [16:0] rank_out;

    cmd_item_t   pending_q[$];
    answer_t     answer_q[$];
    cmd_item_t   cur_item;

    // shadow of the block state
    logic [63:0] vec_mem[1024];
    logic [16:0] samp_mem[1024];
    logic        built;
    logic [16:0] len_reg;
    logic [10:0] rate_reg;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_reqs;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          fail_cnt    = 0;
    int          checked_cnt = 0;
    int          rank_ok_cnt = 0;
    int          phase_cnt;
    int          sent_cnt    = 0;
    int          taken_cnt   = 0;

    bitvector_rank_engine_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .command    (command),
        .bit_index  (bit_index),
        .bit_value  (bit_value),
        .word_index (word_index),
        .word_value (word_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .status     (status),
        .bit_out    (bit_out),
        .rank_out   (rank_out)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int usable_bits();
        return (len_reg > 17'd65536) ? 65536 : int'(len_reg);
    endfunction

    function automatic int used_words();
        return (usable_bits() + 63) / 64;
    endfunction

    // works out the answer of one transaction and updates the shadow state
    function automatic answer_t rank_engine_predict(cmd_item_t it);
        answer_t     a;
        int          nbits;
        int          nwords;
        int          k;
        int          w;
        int          off;
        int          sb;
        logic [16:0] acc;
        nbits  = usable_bits();
        nwords = used_words();
        k      = (rate_reg == 0) ? 1 : int'(rate_reg);
        a.st    = bre_pkg::ST_OK;
        a.bit_o = 1'b0;
        a.rank  = '0;
        w   = int'(it.bidx) / 64;
        off = int'(it.bidx) % 64;
        if (it.cmd == bre_pkg::CMD_LOAD) begin
            if (int'(it.widx) >= nwords)
                a.st = bre_pkg::ST_RANGE;
            else
            begin
                vec_mem[it.widx] = it.wval;
                built = 1'b0;
            end
        end
        else if (it.cmd == bre_pkg::CMD_WRITE || it.cmd == bre_pkg::CMD_READ
                 || it.cmd == bre_pkg::CMD_RANK) begin
            if (int'(it.bidx) >= nbits)
                a.st = bre_pkg::ST_RANGE;
            else if (it.cmd == bre_pkg::CMD_WRITE)
            begin
                vec_mem[w][off] = it.bval;
                built = 1'b0;
            end
            else if (it.cmd == bre_pkg::CMD_READ)
                a.bit_o = vec_mem[w][off];
            else if (!built)
                a.st = bre_pkg::ST_UNBUILT;
            else
            begin
                sb  = w / k;
                acc = samp_mem[sb];
                for (int b = sb * k; b < w; b++)
                    acc = acc + 17'($countones(vec_mem[b]));
                acc = acc + 17'($countones(vec_mem[w] & ({64{1'b1}} >> (63 - off))));
                a.rank = acc;
            end
        end
        else if (it.cmd == bre_pkg::CMD_BUILD) begin
            acc = '0;
            for (int i = 0; i < nwords; i++)
            begin
                if (i % k == 0)
                    samp_mem[i / k] = acc;
                acc = acc + 17'($countones(vec_mem[i]));
            end
            built = 1'b1;
        end
        return a;
    endfunction

    // acceptance: predict on the input side, check on the output side
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && cmd_valid && cmd_ready) begin
            answer_q.push_back(rank_engine_predict(cur_item));
            taken_cnt++;
        end
        if (rst_n && res_valid && res_ready) begin
            if (answer_q.size() == 0)
            begin
                $error("result with no transaction outstanding: status %0d", status);
                fail_cnt++;
            end
            else
            begin
                exp_a = answer_q.pop_front();
                checked_cnt++;
                if (status != exp_a.st) begin
                    $error("status: expected %0d, got %0d", exp_a.st, status);
                    fail_cnt++;
                end
                if (bit_out != exp_a.bit_o) begin
                    $error("bit_out: expected %0d, got %0d", exp_a.bit_o, bit_out);
                    fail_cnt++;
                end
                if (rank_out != exp_a.rank) begin
                    $error("rank_out: expected %0d, got %0d", exp_a.rank, rank_out);
                    fail_cnt++;
                end
                if (exp_a.st == bre_pkg::ST_OK && exp_a.rank != 0)
                    rank_ok_cnt++;
            end
        end
    end

    // command driver: holds the transaction until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || taken_cnt == sent_cnt) begin
            if (pending_q.size() == 0 || $urandom_range(99) < send_idle_pct)
                cmd_valid <= 1'b0;
            else
            begin
                cur_item   = pending_q.pop_front();
                sent_cnt++;
                cmd_valid  <= 1'b1;
                command    <= cur_item.cmd;
                bit_index  <= cur_item.bidx;
                bit_value  <= cur_item.bval;
                word_index <= cur_item.widx;
                word_value <= cur_item.wval;
            end
        end
    end

    // result acceptor, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic wait_drained();
        while (pending_q.size() != 0 || answer_q.size() != 0 || cmd_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == bre_pkg::REG_LENGTH)
            len_reg = val;
        else
            rate_reg = val[10:0];
        built = 1'b0;
    endtask

    task automatic push_cmd(logic [2:0] c, int bi, logic bv, int wi, logic [63:0] wv);
        cmd_item_t it;
        it.cmd  = c;
        it.bidx = 16'(bi);
        it.bval = bv;
        it.widx = 10'(wi);
        it.wval = wv;
        pending_q.push_back(it);
    endtask

    // new setting, then every word in use is loaded so no read touches an unwritten word
    task automatic start_phase(logic [16:0] len, logic [16:0] rate, int sidle, int rstall);
        wait_drained();
        phase_cnt++;
        write_reg(bre_pkg::REG_LENGTH, len);
        write_reg(bre_pkg::REG_SAMPLE, rate);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (int i = 0; i < used_words(); i++)
            push_cmd(bre_pkg::CMD_LOAD, 0, 1'b0, i, {$urandom, $urandom});
    endtask

    task automatic push_random(int n);
        int          nbits;
        int          nwords;
        int          r;
        int          bi;
        int          wi;
        logic [63:0] wv;
        nbits  = usable_bits();
        nwords = used_words();
        for (int j = 0; j < n; j++) begin
            r  = $urandom_range(99);
            bi = ($urandom_range(9) == 0) ? int'($urandom_range(65535))
                                          : int'($urandom_range(nbits + 2));
            if (bi > 65535)
                bi = 65535;
            wi = ($urandom_range(9) == 0) ? int'($urandom_range(1023))
                                          : int'($urandom_range(nwords));
            if (wi > 1023)
                wi = 1023;
            case ($urandom_range(3))
                0: wv = '0;
                1: wv = '1;
                default: wv = {$urandom, $urandom};
            endcase
            if (r < 30)
                push_cmd(bre_pkg::CMD_RANK, bi, 1'b0, wi, wv);
            else if (r < 50)
                push_cmd(bre_pkg::CMD_READ, bi, 1'b0, wi, wv);
            else if (r < 65)
                push_cmd(bre_pkg::CMD_WRITE, bi, 1'($urandom), wi, wv);
            else if (r < 78)
                push_cmd(bre_pkg::CMD_LOAD, bi, 1'($urandom), wi, wv);
            else if (r < 95)
                push_cmd(bre_pkg::CMD_BUILD, bi, 1'($urandom), wi, wv);
            else
                push_cmd(3'($urandom_range(7, int'(bre_pkg::CMD_RANK) + 1)), bi,
                         1'($urandom), wi, wv);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = bre_pkg::REG_LENGTH;
        cfg_data       = '0;
        command        = bre_pkg::CMD_LOAD;
        bit_index      = '0;
        bit_value      = 1'b0;
        word_index     = '0;
        word_value     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_reqs      = 0;
        phase_cnt      = 0;
        built          = 1'b0;
        len_reg        = '0;
        rate_reg       = 11'd1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty vector: build stores nothing, everything else is out of range
        push_cmd(bre_pkg::CMD_BUILD, 0, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 0, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_READ, 0, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_WRITE, 0, 1'b1, 0, '0);
        push_cmd(bre_pkg::CMD_LOAD, 0, 1'b0, 0, '1);

        // short vector with a zero sample rate, partial last word
        start_phase(17'd200, 17'd0, 0, 0);
        push_cmd(bre_pkg::CMD_LOAD, 0, 1'b0, 1, '1);
        push_cmd(bre_pkg::CMD_LOAD, 0, 1'b0, 2, '0);
        push_cmd(bre_pkg::CMD_LOAD, 0, 1'b0, 3, '1);   // stray bits above bit 199
        push_cmd(bre_pkg::CMD_WRITE, 5, 1'b1, 0, '0);
        push_cmd(bre_pkg::CMD_WRITE, 199, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_READ, 5, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 10, 1'b0, 0, '0);  // not built yet
        push_cmd(bre_pkg::CMD_BUILD, 0, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 0, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 63, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 198, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 199, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 200, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_READ, 65535, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_LOAD, 0, 1'b0, 4, '1);
        push_cmd(bre_pkg::CMD_LOAD, 0, 1'b0, 1023, '1);
        push_cmd(3'(int'(bre_pkg::CMD_RANK) + 1), 3, 1'b1, 3, '1);
        push_cmd(3'(int'(bre_pkg::CMD_RANK) + 2), 3, 1'b1, 3, '1);
        push_cmd(3'(int'(bre_pkg::CMD_RANK) + 3), 3, 1'b1, 3, '1);
        push_cmd(bre_pkg::CMD_WRITE, 1, 1'b1, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 150, 1'b0, 0, '0);

        start_phase(17'd1000, 17'd3, 0, 0);
        push_cmd(bre_pkg::CMD_BUILD, 0, 1'b0, 0, '0);
        push_random(70);

        start_phase(17'd333, 17'd1, 79, 0);
        push_cmd(bre_pkg::CMD_BUILD, 0, 1'b0, 0, '0);
        push_random(50);

        // receiver holds off while commands keep coming
        start_phase(17'd4096, 17'd7, 0, 79);
        push_cmd(bre_pkg::CMD_BUILD, 0, 1'b0, 0, '0);
        push_random(50);
        hold_reqs++;

        start_phase(17'd640, 17'd16, 9, 9);
        push_cmd(bre_pkg::CMD_BUILD, 0, 1'b0, 0, '0);
        push_random(40);

        start_phase(17'd64, 17'd1024, 0, 0);
        push_cmd(bre_pkg::CMD_BUILD, 0, 1'b0, 0, '0);
        push_random(30);

        // all config bits set: length caps at the full store, one sample only
        start_phase(17'h1ffff, 17'h7ff, 0, 0);
        push_cmd(bre_pkg::CMD_BUILD, 0, 1'b0, 0, '0);
        push_cmd(bre_pkg::CMD_RANK, 65535, 1'b0, 0, '0);
        push_random(10);

        wait_drained();
        repeat (50) @(posedge clk);
        $display("checked %0d results over %0d settings, %0d nonzero ranks",
                 checked_cnt, phase_cnt, rank_ok_cnt);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
